// ===== hw/rtl/slewlim_pkg.sv =====
// Shared types and constants for the stereo slew limiter.
// Used by slewlim_ctrl, slewlim_dp and the top level; depends on nothing.
`default_nettype none

package slewlim_pkg;

  localparam int DEF_SAMPLE_BITS       = 24;
  localparam int DEF_COS_TABLE_ENTRIES = 256;

  localparam int                      THRESH_BITS  = 24;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 24'd4194304;  // 1.0 in Q2.22
  localparam int                      COS_BITS     = 18;           // Q1.17 table entries
  localparam int                      ABS_BITS     = 17;           // |last| in Q16, up to 1.0

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_IDX,
    S_ROM,
    S_LIM,
    S_RND,
    S_UPD,
    S_PUSH
  } state_t;

  // Per-cycle strobes from the controller to the datapath
  typedef struct packed {
    logic load;
    logic sq;
    logic idx;
    logic rom;
    logic lim;
    logic rnd;
    logic upd;
    logic push;
    logic ch;    // 0 = left, 1 = right
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slewlim_ctrl.sv =====
// Sequencer for the stereo slew limiter: walks each channel through the shared
// multiplier and table, then hands the frame to the output register. Uses slewlim_pkg.
`default_nettype none

module slewlim_ctrl
  import slewlim_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   ch;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        ch <= 1'b0;
      end else if (cmd.upd) begin
        ch <= ~ch;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_SQ;
      S_SQ:    state_next = S_IDX;
      S_IDX:   state_next = S_ROM;
      S_ROM:   state_next = S_LIM;
      S_LIM:   state_next = S_RND;
      S_RND:   state_next = S_UPD;
      S_UPD:   state_next = ch ? S_PUSH : S_SQ;
      S_PUSH:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.ch   = ch;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SQ:    cmd.sq  = 1'b1;
      S_IDX:   cmd.idx = 1'b1;
      S_ROM:   cmd.rom = 1'b1;
      S_LIM:   cmd.lim = 1'b1;
      S_RND:   cmd.rnd = 1'b1;
      S_UPD:   cmd.upd = 1'b1;
      S_PUSH:  cmd.push = slot_free;
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slewlim_dp.sv =====
// Datapath of the stereo slew limiter: sample and history registers, threshold
// register, shared multiplier, cosine ROM and the limit/saturate step. Uses slewlim_pkg.
`default_nettype none

module slewlim_dp
  import slewlim_pkg::*;
#(
  parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS,
  parameter int COS_TABLE_ENTRIES = DEF_COS_TABLE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  input  logic                          cfg_we,
  input  logic [THRESH_BITS-1:0]        cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out
);

  localparam int F      = SAMPLE_BITS - 1;
  localparam int IW     = $clog2(COS_TABLE_ENTRIES);
  localparam int PW     = THRESH_BITS + COS_BITS;       // shared multiplier product
  localparam int SQW    = 2 * ABS_BITS - 1;             // |last|^2 <= 2^32
  localparam int SW     = SQW + IW + 1;                 // index product plus rounding
  localparam int LW     = SAMPLE_BITS + 2;              // step limit
  localparam int EW     = SAMPLE_BITS + 3;              // signed update arithmetic
  localparam int ROM_W  = COS_TABLE_ENTRIES * COS_BITS;

  localparam logic [63:0]    Den       = 64'(COS_TABLE_ENTRIES - 1);
  localparam logic [SW-1:0]  IDX_MUL   = SW'(COS_TABLE_ENTRIES - 1);
  localparam logic [SW-1:0]  IDX_ROUND = SW'(1) << 31;
  localparam logic [IW+1:0]  IDX_MAX   = (IW + 2)'(COS_TABLE_ENTRIES - 1);
  localparam logic [PW:0]    LIM_ROUND = (PW + 1)'(1) << (38 - F);
  localparam logic signed [EW-1:0] OUT_HI = {{(EW-SAMPLE_BITS+1){1'b0}}, {F{1'b1}}};
  localparam logic signed [EW-1:0] OUT_LO = {{(EW-SAMPLE_BITS+1){1'b1}}, {F{1'b0}}};

  // cos(k/(N-1)) by a six-term Taylor series in Q30, rounded to Q1.17
  function automatic logic [COS_BITS-1:0] cos_entry(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sum;
    x   = (((k << 31) / Den) + 64'd1) >> 1;
    x2  = (x * x) >> 30;
    t   = 64'd1 << 30;
    sum = 64'd1 << 30;
    t   = ((t * x2) >> 30) / 64'd2;
    sum = sum - t;
    t   = ((t * x2) >> 30) / 64'd12;
    sum = sum + t;
    t   = ((t * x2) >> 30) / 64'd30;
    sum = sum - t;
    t   = ((t * x2) >> 30) / 64'd56;
    sum = sum + t;
    t   = ((t * x2) >> 30) / 64'd90;
    sum = sum - t;
    return COS_BITS'((sum + 64'd4096) >> 13);
  endfunction

  function automatic logic [ROM_W-1:0] build_rom();
    logic [ROM_W-1:0] rom;
    rom = '0;
    for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
      rom[k*COS_BITS +: COS_BITS] = cos_entry(64'(k));
    end
    return rom;
  endfunction

  localparam logic [ROM_W-1:0] COS_ROM = build_rom();

  logic signed [SAMPLE_BITS-1:0] x_left;
  logic signed [SAMPLE_BITS-1:0] x_right;
  logic signed [SAMPLE_BITS-1:0] left_last;
  logic signed [SAMPLE_BITS-1:0] right_last;
  logic [THRESH_BITS-1:0]        threshold;
  logic [PW-1:0]                 prod;
  logic [IW-1:0]                 idx;
  logic [COS_BITS-1:0]           cos_q;
  logic [LW-1:0]                 lim;

  logic signed [SAMPLE_BITS-1:0] x_cur;
  logic signed [SAMPLE_BITS-1:0] prev;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [ABS_BITS-1:0]           a;
  logic [THRESH_BITS-1:0]        op_a;
  logic [COS_BITS-1:0]           op_b;
  logic [SW-1:0]                 idx_sum;
  logic [IW+1:0]                 idx_hi;
  logic [PW:0]                   lim_sum;
  logic signed [EW-1:0]          xs;
  logic signed [EW-1:0]          ps;
  logic signed [EW-1:0]          ls;
  logic signed [EW-1:0]          diff;
  logic signed [EW-1:0]          res;
  logic signed [EW-1:0]          res_sat;

  assign x_cur = cmd.ch ? x_right : x_left;
  assign prev  = cmd.ch ? right_last : left_last;
  assign mag   = prev[SAMPLE_BITS-1] ? SAMPLE_BITS'(-prev) : SAMPLE_BITS'(prev);

  // |last| to Q16
  generate
    if (F >= 16) begin : g_shr
      assign a = ABS_BITS'(mag >> (F - 16));
    end else begin : g_shl
      assign a = ABS_BITS'(mag) << (16 - F);
    end
  endgenerate

  // one multiplier for |last|^2 and threshold * cos
  assign op_a = cmd.sq ? THRESH_BITS'(a) : threshold;
  assign op_b = cmd.sq ? COS_BITS'(a) : cos_q;

  assign idx_sum = SW'(prod[SQW-1:0]) * IDX_MUL + IDX_ROUND;
  assign idx_hi  = idx_sum[SW-1:32];

  assign lim_sum = (PW + 1)'(prod) + LIM_ROUND;

  assign xs   = EW'(x_cur);
  assign ps   = EW'(prev);
  assign ls   = $signed({1'b0, lim});
  assign diff = xs - ps;

  always_comb begin
    if (diff > ls) begin
      res = ps + ls;
    end else if (-diff > ls) begin
      res = ps - ls;
    end else begin
      res = xs;
    end
    if (res > OUT_HI) begin
      res_sat = OUT_HI;
    end else if (res < OUT_LO) begin
      res_sat = OUT_LO;
    end else begin
      res_sat = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESH_RESET;
      left_last  <= '0;
      right_last <= '0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (cmd.upd) begin
        if (cmd.ch) begin
          right_last <= res_sat[SAMPLE_BITS-1:0];
        end else begin
          left_last <= res_sat[SAMPLE_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_left  <= left_sample;
      x_right <= right_sample;
    end
    if (cmd.sq || cmd.lim) begin
      prod <= op_a * op_b;
    end
    if (cmd.idx) begin
      idx <= (idx_hi > IDX_MAX) ? IDX_MAX[IW-1:0] : idx_hi[IW-1:0];
    end
    if (cmd.rom) begin
      cos_q <= COS_ROM[idx*COS_BITS +: COS_BITS];
    end
    if (cmd.rnd) begin
      lim <= LW'(lim_sum >> (39 - F));
    end
    if (cmd.push) begin
      left_out  <= left_last;
      right_out <= right_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stereo_level_dependent_slew_limiter_core.sv =====
// Stereo level-dependent slew limiter, top level. Instantiates slewlim_ctrl and
// slewlim_dp; uses slewlim_pkg.
//
// One item is a stereo frame of signed Q1.F samples (F = SAMPLE_BITS-1). Each channel's
// step is limited to slew_threshold * cos(last^2), cos taken from a nearest-entry ROM
// over [0,1]; outputs saturate to the sample range and become the new history. Both
// histories reset to zero, slew_threshold to 1.0 (Q2.22). An item is accepted only in
// the idle state, once the previous one is done: the two channels run one after the
// other, each through square, index, ROM, limit and round steps and the history update,
// on a single shared 24x18 multiplier and the registered cosine ROM; then the output
// register is loaded once free. A new item is taken while the previous result waits on out_ready.
// cfg_we writes slew_threshold; write it only while the block is idle.
`default_nettype none

module stereo_level_dependent_slew_limiter_core
  import slewlim_pkg::*;
#(
  parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS,
  parameter int COS_TABLE_ENTRIES = DEF_COS_TABLE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  input  logic                          cfg_we,
  input  logic [THRESH_BITS-1:0]        cfg_wdata
);

  dp_cmd_t cmd;

  slewlim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  slewlim_dp #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .left_out     (left_out),
    .right_out    (right_out)
  );

endmodule

`default_nettype wire
